// ===== rtl/ccfg_pkg.sv =====
// Shared types and constants for the coulomb counting fuel gauge.
// No dependencies.
`timescale 1ns / 1ps
package ccfg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_EMPTY_MV  = 3'd0;
    localparam logic [2:0] REG_FULL_MV   = 3'd1;
    localparam logic [2:0] REG_EMPTY_MAH = 3'd2;
    localparam logic [2:0] REG_DESIGN    = 3'd3;
    localparam logic [2:0] REG_INITIAL   = 3'd4;
    localparam logic [2:0] REG_RECAL     = 3'd5;

    localparam logic [15:0] RECAL20_MV   = 16'd25040;
    localparam logic [15:0] RECAL5_MV    = 16'd22400;
    localparam logic [15:0] RELEARN_MIN  = 16'd10000;
    localparam logic [15:0] RECAL20_MAH  = 16'd2400;
    localparam logic [15:0] RECAL5_MAH   = 16'd600;
    localparam logic signed [16:0] FULL_CUR_MAX = 17'sd800;
    localparam logic signed [16:0] RECAL_CUR_MIN = -17'sd2000;

    // Largest per-sample magnitudes, used to size the window sums.
    localparam int MV_MAX     = 40950;
    localparam int MA_MAG_MAX = 32768;

    // Reciprocals for the fixed divisions by 60 and by 100, both taken
    // with a right shift of RECIP_SHIFT. Exact for operands below 2^16.
    localparam int RECIP_SHIFT          = 23;
    localparam logic [17:0] DIV60_RECIP  = 18'd139811;
    localparam logic [16:0] DIV100_RECIP = 17'd83887;

    // One classified sample, passed from the front to the back.
    typedef struct packed {
        logic [15:0]        mv;
        logic signed [15:0] ma;
        logic               chg;
    } sample_t;

endpackage

// ===== rtl/ccfg_front.sv =====
// Front part: converts an input sample to millivolts and milliamps.
// Depends on ccfg_pkg.
`timescale 1ns / 1ps
module ccfg_front
(
    input  logic [11:0]        battery_voltage_code,
    input  logic [11:0]        battery_current_code,
    input  logic               charging,
    output ccfg_pkg::sample_t  sample
);

    logic signed [12:0] d;
    logic signed [19:0] prod;
    logic [19:0]        mag;
    logic [17:0]        q;
    logic signed [18:0] sq;

    // Scale voltage by 10 and current by 75/4 with truncation toward zero and saturation.
    always_comb
    begin
        d    = $signed({1'b0, battery_current_code}) - 13'sd2000;
        prod = 20'(d) * 20'sd75;
        mag  = prod[19] ? 20'(-prod) : prod;
        q    = mag[19:2];
        sq   = prod[19] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sample.mv  = 16'(battery_voltage_code) * 16'd10;
        sample.chg = charging;
        if (d > -13'sd5 && d < 13'sd5)
            sample.ma = '0;
        else if (sq > 19'sd32767)
            sample.ma = 16'sh7fff;
        else if (sq < -19'sd32768)
            sample.ma = 16'sh8000;
        else
            sample.ma = sq[15:0];
    end

endmodule

// ===== rtl/ccfg_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module ccfg_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [21:0] num,
    input  logic [15:0] den,
    output logic        busy,
    output logic [21:0] quo
);

    logic [21:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [4:0]  n_reg, n_next;
    logic        b_reg, b_next;
    logic [17:0] trial;

    // Shift in one numerator bit and subtract when it fits.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        b_next = b_reg;
        trial  = {r_reg, q_reg[21]} - {2'b0, den};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            n_next = 5'd21;
            b_next = 1'b1;
        end
        else if (b_reg)
        begin
            if (!trial[17])
            begin
                r_next = trial[16:0];
                q_next = {q_reg[20:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[15:0], q_reg[21]};
                q_next = {q_reg[20:0], 1'b0};
            end
            n_next = n_reg - 5'd1;
            if (n_reg == '0)
                b_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy = b_reg;
    assign quo  = q_reg;

endmodule

// ===== rtl/ccfg_back.sv =====
// Back part: window accumulation, charge counting, capacity learning, flags.
// Depends on ccfg_pkg and ccfg_div.
`timescale 1ns / 1ps
module ccfg_back
#(
    parameter int WINDOW_SAMPLES = 60,
    parameter int LOW_DEBOUNCE   = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ccfg_pkg::sample_t  sample,
    input  logic [15:0]        empty_voltage_mv,
    input  logic [15:0]        full_voltage_mv,
    input  logic [15:0]        empty_charge_mah,
    input  logic [15:0]        design_capacity_mah,
    input  logic [15:0]        initial_charge_mah,
    input  logic               voltage_recal_enable,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        battery_mv,
    output logic signed [15:0] battery_ma,
    output logic [7:0]         charge_percent,
    output logic               low_capacity,
    output logic               low_voltage,
    output logic               window_done,
    output logic [15:0]        remaining_mah,
    output logic [15:0]        learned_capacity_mah,
    output logic               store_capacity
);

    localparam int WW = $clog2(WINDOW_SAMPLES + 1);
    localparam int LW = $clog2(LOW_DEBOUNCE + 2);
    localparam logic [WW-1:0] WLAST = WW'(WINDOW_SAMPLES - 1);
    localparam logic [LW-1:0] LMAX  = LW'(LOW_DEBOUNCE);

    // Window sum widths and the reciprocal for the window average.
    localparam int VAW = $clog2(WINDOW_SAMPLES * ccfg_pkg::MV_MAX + 1);
    localparam int CAW = $clog2(WINDOW_SAMPLES * ccfg_pkg::MA_MAG_MAX) + 1;
    localparam int AL  = $clog2(WINDOW_SAMPLES);
    localparam int VSH = VAW + AL;
    localparam int KW  = VAW + 1;
    localparam int PW  = VAW + KW;
    localparam logic [KW-1:0] VREC = KW'(((64'd1 << VSH) + 64'(WINDOW_SAMPLES) - 64'd1)
                                         / 64'(WINDOW_SAMPLES));

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_PCT0 = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_VAVG = 4'd4;
    localparam logic [3:0] S_CAVG = 4'd5;
    localparam logic [3:0] S_DLT  = 4'd6;
    localparam logic [3:0] S_APPL = 4'd7;
    localparam logic [3:0] S_CAPD = 4'd8;
    localparam logic [3:0] S_PCT  = 4'd9;
    localparam logic [3:0] S_RCAL = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]  st_reg;
    logic        started_reg;
    logic [WW-1:0] wcnt_reg;
    logic [VAW-1:0] vacc_reg;
    logic signed [CAW-1:0] cacc_reg;
    logic [15:0] chg_reg;
    logic [15:0] cap_reg;
    logic [7:0]  pct_reg;
    logic        arm_reg, lowcap_reg, lowv_reg, done_reg, store_reg;
    logic [LW-1:0] run_reg;
    ccfg_pkg::sample_t s_reg;
    logic [15:0] vavg_reg;
    logic signed [16:0] cavg_reg;
    logic [15:0] capd_reg;
    logic        wait_reg;
    logic        phase_reg;

    // Divider for the percent, the only division by a variable.
    logic        dstart, dbusy;
    logic [21:0] dnum, dquo;
    logic [15:0] dden;

    ccfg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dnum),
        .den   (dden),
        .busy  (dbusy),
        .quo   (dquo)
    );

    logic [CAW-1:0] cmag;
    logic [16:0]    cavg_mag;
    logic [VAW-1:0] mul_a;
    logic [KW-1:0]  mul_k;
    logic [PW-1:0]  mul_p;
    logic [15:0]    avg_q;
    logic [15:0]    small_q;
    logic           vlow;

    // Constant divisions by reciprocal multiplication, one per state.
    always_comb
    begin
        cmag     = cacc_reg[CAW-1] ? CAW'(-cacc_reg) : CAW'(cacc_reg);
        cavg_mag = cavg_reg[16] ? 17'(-cavg_reg) : 17'(cavg_reg);
        mul_a    = '0;
        mul_k    = '0;
        unique case (st_reg)
            S_VAVG:
            begin
                mul_a = vacc_reg;
                mul_k = VREC;
            end
            S_CAVG:
            begin
                mul_a = VAW'(cmag);
                mul_k = VREC;
            end
            S_DLT:
            begin
                mul_a = VAW'(cavg_mag);
                mul_k = KW'(ccfg_pkg::DIV60_RECIP);
            end
            S_CAPD:
            begin
                mul_a = VAW'(cap_reg);
                mul_k = KW'(ccfg_pkg::DIV100_RECIP);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        mul_p   = PW'(mul_a) * PW'(mul_k);
        avg_q   = 16'(mul_p >> VSH);
        small_q = 16'(mul_p >> ccfg_pkg::RECIP_SHIFT);
        vlow    = s_reg.mv < empty_voltage_mv;
    end

    // Percent division start.
    always_comb
    begin
        dnum   = 22'(chg_reg);
        dden   = capd_reg;
        dstart = 1'b0;
        if (!wait_reg && (st_reg == S_PCT0 || st_reg == S_PCT))
            dstart = capd_reg != '0;
    end

    assign in_ready = st_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            started_reg <= 1'b0;
            wcnt_reg    <= '0;
            vacc_reg    <= '0;
            cacc_reg    <= '0;
            chg_reg     <= '0;
            cap_reg     <= '0;
            pct_reg     <= '0;
            arm_reg     <= 1'b0;
            lowcap_reg  <= 1'b0;
            lowv_reg    <= 1'b0;
            run_reg     <= '0;
            done_reg    <= 1'b0;
            store_reg   <= 1'b0;
            wait_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            capd_reg    <= '0;
            s_reg       <= '0;
            vavg_reg    <= '0;
            cavg_reg    <= '0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        s_reg     <= sample;
                        done_reg  <= 1'b0;
                        store_reg <= 1'b0;
                        st_reg    <= started_reg ? S_ACC : S_INIT;
                    end
                S_INIT:
                begin
                    started_reg <= 1'b1;
                    cap_reg     <= design_capacity_mah;
                    chg_reg     <= initial_charge_mah;
                    phase_reg   <= 1'b0;
                    st_reg      <= S_CAPD;
                end
                S_ACC:
                begin
                    vacc_reg <= vacc_reg + VAW'(s_reg.mv);
                    cacc_reg <= cacc_reg + CAW'(s_reg.ma);
                    if (wcnt_reg == WLAST)
                    begin
                        wcnt_reg <= '0;
                        done_reg <= 1'b1;
                        st_reg   <= S_VAVG;
                    end
                    else
                    begin
                        wcnt_reg <= wcnt_reg + 1'b1;
                        st_reg   <= S_FIN;
                    end
                end
                S_VAVG:
                begin
                    vavg_reg <= avg_q;
                    st_reg   <= S_CAVG;
                end
                S_CAVG:
                begin
                    cavg_reg <= cacc_reg[CAW-1] ? -$signed({1'b0, avg_q})
                                                : $signed({1'b0, avg_q});
                    st_reg   <= S_DLT;
                end
                S_DLT:
                begin
                    capd_reg <= small_q;
                    st_reg   <= S_APPL;
                end
                S_CAPD:
                begin
                    capd_reg <= small_q;
                    st_reg   <= phase_reg ? S_PCT : S_PCT0;
                end
                S_PCT0, S_PCT:
                begin
                    if (!wait_reg)
                    begin
                        if (capd_reg == '0)
                        begin
                            pct_reg <= (chg_reg == '0) ? 8'd0 : 8'd255;
                            st_reg  <= (st_reg == S_PCT0) ? S_ACC : S_RCAL;
                        end
                        else
                            wait_reg <= 1'b1;
                    end
                    else if (!dbusy)
                    begin
                        wait_reg <= 1'b0;
                        pct_reg  <= (dquo > 22'd255) ? 8'd255 : dquo[7:0];
                        st_reg   <= (st_reg == S_PCT0) ? S_ACC : S_RCAL;
                    end
                end
                S_APPL:
                begin
                    // capd_reg holds |delta| here; cavg sign gives direction.
                    logic [15:0] c;
                    logic        a;
                    c = chg_reg;
                    if (cavg_reg[16])
                        c = (chg_reg < capd_reg) ? 16'd0 : chg_reg - capd_reg;
                    else
                        c = (17'(chg_reg) + 17'(capd_reg) > 17'd65535) ? 16'hffff
                            : chg_reg + capd_reg;
                    a = arm_reg;
                    if (vavg_reg <= ccfg_pkg::RECAL20_MV && (s_reg.chg || lowcap_reg))
                        a = 1'b1;
                    if (vavg_reg < empty_voltage_mv && !s_reg.chg)
                        c = empty_charge_mah;
                    else if (vavg_reg > full_voltage_mv && s_reg.chg &&
                             cavg_reg < ccfg_pkg::FULL_CUR_MAX)
                    begin
                        if (a && c <= cap_reg && c >= ccfg_pkg::RELEARN_MIN)
                        begin
                            cap_reg   <= c;
                            store_reg <= 1'b1;
                        end
                        else
                            c = cap_reg;
                        a = 1'b0;
                    end
                    else if (c >= cap_reg)
                        c = cap_reg;
                    else if (c <= empty_charge_mah)
                        c = empty_charge_mah;
                    if (vavg_reg < full_voltage_mv && !s_reg.chg)
                        a = 1'b0;
                    chg_reg   <= c;
                    arm_reg   <= a;
                    phase_reg <= 1'b1;
                    st_reg    <= S_CAPD;
                end
                S_RCAL:
                begin
                    if (voltage_recal_enable && cavg_reg >= ccfg_pkg::RECAL_CUR_MIN)
                    begin
                        if (vavg_reg <= ccfg_pkg::RECAL5_MV &&
                            (pct_reg > 8'd5))
                        begin
                            chg_reg <= ccfg_pkg::RECAL5_MAH;
                            pct_reg <= 8'd5;
                        end
                        else if (pct_reg > 8'd20 && vavg_reg <= ccfg_pkg::RECAL20_MV)
                        begin
                            chg_reg <= ccfg_pkg::RECAL20_MAH;
                            pct_reg <= 8'd20;
                        end
                    end
                    vacc_reg <= '0;
                    cacc_reg <= '0;
                    st_reg   <= S_FIN;
                end
                S_FIN:
                begin
                    lowcap_reg <= pct_reg <= 8'd20;
                    if (vlow)
                    begin
                        if (run_reg <= LMAX)
                        begin
                            run_reg <= run_reg + 1'b1;
                            if (run_reg == LMAX)
                                lowv_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        run_reg  <= '0;
                        lowv_reg <= 1'b0;
                    end
                    st_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                        st_reg <= S_IDLE;
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid            = st_reg == S_OUT;
    assign battery_mv           = s_reg.mv;
    assign battery_ma           = s_reg.ma;
    assign charge_percent       = pct_reg;
    assign low_capacity         = lowcap_reg;
    assign low_voltage          = lowv_reg;
    assign window_done          = done_reg;
    assign remaining_mah        = chg_reg;
    assign learned_capacity_mah = cap_reg;
    assign store_capacity       = store_reg;

endmodule

// ===== rtl/coulomb_counting_fuel_gauge_unit.sv =====
// Coulomb counting fuel gauge.
// Uses the sample conversion front, a two-entry queue and the sequencing back end.
// Usage:
//   Input channel in_valid/in_ready carries one battery sample (voltage code,
//   current code, charging flag). Output channel out_valid/out_ready returns
//   one result item per sample. Config writes use cfg_we, cfg_index, cfg_data
//   and must happen while the block is idle.
//   A sample that does not close a window passes through S_ACC, S_FIN and S_OUT in
//   the back end. A window close forms the averages and the charge step by reciprocal
//   multiplication, one state each, and runs the percent through a bit-serial
//   divider; the very first sample also loads the design capacity and computes a
//   percent before it is accumulated.
//   The front converts and a two-entry queue holds up to two samples, so the input
//   side keeps accepting until the queue is full while the back end works or the
//   receiver stalls. Reset clears all counters, the capacity and the start flag;
//   configuration registers return to their default values.
//   A stalled receiver holds the result; the back end waits until it is taken.
`timescale 1ns / 1ps
module coulomb_counting_fuel_gauge_unit
#(
    parameter int WINDOW_SAMPLES = 60,
    parameter int LOW_DEBOUNCE   = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        battery_voltage_code,
    input  logic [11:0]        battery_current_code,
    input  logic               charging,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        battery_mv,
    output logic signed [15:0] battery_ma,
    output logic [7:0]         charge_percent,
    output logic               low_capacity,
    output logic               low_voltage,
    output logic               window_done,
    output logic [15:0]        remaining_mah,
    output logic [15:0]        learned_capacity_mah,
    output logic               store_capacity
);

    logic [15:0] empty_mv_reg, full_mv_reg, empty_mah_reg, design_reg, initial_reg;
    logic        recal_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_mv_reg  <= 16'd22000;
            full_mv_reg   <= 16'd28800;
            empty_mah_reg <= 16'd0;
            design_reg    <= 16'd12000;
            initial_reg   <= 16'd6000;
            recal_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ccfg_pkg::REG_EMPTY_MV:  empty_mv_reg  <= cfg_data;
                ccfg_pkg::REG_FULL_MV:   full_mv_reg   <= cfg_data;
                ccfg_pkg::REG_EMPTY_MAH: empty_mah_reg <= cfg_data;
                ccfg_pkg::REG_DESIGN:    design_reg    <= cfg_data;
                ccfg_pkg::REG_INITIAL:   initial_reg   <= cfg_data;
                ccfg_pkg::REG_RECAL:     recal_reg     <= cfg_data[0];
                default:                 recal_reg     <= recal_reg;
            endcase
        end
    end

    ccfg_pkg::sample_t conv;

    ccfg_front u_front
    (
        .battery_voltage_code (battery_voltage_code),
        .battery_current_code (battery_current_code),
        .charging             (charging),
        .sample               (conv)
    );

    // Two-entry queue between front and back.
    ccfg_pkg::sample_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       b_ready, push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign push     = in_valid && in_ready;
    assign pop      = (cnt_reg != 2'd0) && b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= conv;
    end

    ccfg_back
    #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .LOW_DEBOUNCE   (LOW_DEBOUNCE)
    )
    u_back
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (cnt_reg != 2'd0),
        .in_ready             (b_ready),
        .sample               (q_reg[rp_reg]),
        .empty_voltage_mv     (empty_mv_reg),
        .full_voltage_mv      (full_mv_reg),
        .empty_charge_mah     (empty_mah_reg),
        .design_capacity_mah  (design_reg),
        .initial_charge_mah   (initial_reg),
        .voltage_recal_enable (recal_reg),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .battery_mv           (battery_mv),
        .battery_ma           (battery_ma),
        .charge_percent       (charge_percent),
        .low_capacity         (low_capacity),
        .low_voltage          (low_voltage),
        .window_done          (window_done),
        .remaining_mah        (remaining_mah),
        .learned_capacity_mah (learned_capacity_mah),
        .store_capacity       (store_capacity)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_store_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_capacity |-> window_done) else $error("store without window");
    a_lowcap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> low_capacity == (charge_percent <= 8'd20))
        else $error("low capacity mismatch");
`endif

endmodule
